[sv/mau_pkg.sv]
// ----------------------------------------------------------------------------
// mau_pkg
// Shared types and constants of the attitude update block: channel
// payloads, register indexes, controller states, datapath commands.
// ----------------------------------------------------------------------------
package mau_pkg;

    // input transaction payload
    typedef struct packed {
        logic signed [31:0] rate_x;
        logic signed [31:0] rate_y;
        logic signed [31:0] rate_z;
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
    } t_in;

    // output transaction payload
    typedef struct packed {
        logic signed [31:0] quat_w;
        logic signed [31:0] quat_x;
        logic signed [31:0] quat_y;
        logic signed [31:0] quat_z;
    } t_out;

    // configuration register indexes
    localparam logic [1:0] CFG_KP = 2'd0;
    localparam logic [1:0] CFG_KI = 2'd1;
    localparam logic [1:0] CFG_DT = 2'd2;

    // register reset values
    localparam logic [31:0] KP_RESET = 32'd3276800;
    localparam logic [31:0] KI_RESET = 32'd13107;
    localparam logic [31:0] DT_RESET = 32'd42949673;
    localparam logic signed [31:0] Q_ONE = 32'sh4000_0000;

    // last operation index of each multiply and divide phase
    localparam logic [3:0] LAST_SQA   = 4'd2;
    localparam logic [3:0] LAST_ADIV  = 4'd2;
    localparam logic [3:0] LAST_GRAV  = 4'd7;
    localparam logic [3:0] LAST_ERR   = 4'd5;
    localparam logic [3:0] LAST_INTEG = 4'd2;
    localparam logic [3:0] LAST_GAIN  = 4'd5;
    localparam logic [3:0] LAST_STEP  = 4'd11;
    localparam logic [3:0] LAST_SCALE = 4'd7;
    localparam logic [3:0] LAST_NSUM  = 4'd3;
    localparam logic [3:0] LAST_QDIV  = 4'd3;

    // controller states
    typedef enum logic [3:0] {
        S_IDLE, S_CHK, S_SQA, S_ASQRT, S_ADIV, S_GRAV, S_ERR, S_INTEG,
        S_GAIN, S_STEP, S_SCALE, S_NSUM, S_QSQRT, S_QDIV, S_OUT
    } t_state;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_SQA, OP_ASQRT, OP_ADIV, OP_GRAV, OP_ERR, OP_INTEG,
        OP_GAIN, OP_STEP, OP_SCALE, OP_NSUM, OP_QSQRT, OP_QDIV, OP_OUT
    } t_op;

    // command from controller to datapath
    typedef struct packed {
        t_op        op;
        logic [3:0] idx;
        logic       wb;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic a_zero;
        logic q_zero;
        logic unit_done;
        logic out_free;
    } t_stat;

endpackage

[sv/mau_isqrt.sv]
// ----------------------------------------------------------------------------
// mau_isqrt
// Integer square root of a 64-bit value, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module mau_isqrt
    import mau_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_val,
    output logic        o_done,
    output logic [31:0] o_root
);

    logic [34:0] r_rem;
    logic [31:0] r_root;
    logic [63:0] r_val;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;

    logic [34:0] w_rem_sh;
    logic [34:0] w_trial;
    logic        w_take;

    // trial subtraction of one root digit
    always_comb begin
        w_rem_sh = {r_rem[32:0], r_val[63:62]};
        w_trial  = {1'b0, r_root, 2'b01};
        w_take   = (w_rem_sh >= w_trial);
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // root and remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_root <= '0;
            r_val  <= i_val;
        end else if (r_busy) begin
            r_rem  <= w_take ? (w_rem_sh - w_trial) : w_rem_sh;
            r_root <= {r_root[30:0], w_take};
            r_val  <= {r_val[61:0], 2'b00};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

[sv/mau_div.sv]
// ----------------------------------------------------------------------------
// mau_div
// Restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit
// per cycle; the dividend is below divisor times 2^32 so 32 bits suffice.
// ----------------------------------------------------------------------------
module mau_div
    import mau_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_done,
    output logic [31:0] o_quo
);

    logic [32:0] r_rem;
    logic [31:0] r_lo;
    logic [31:0] r_den;
    logic [31:0] r_quo;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;

    logic [32:0] w_t;
    logic        w_take;

    // partial remainder step
    always_comb begin
        w_t    = {r_rem[31:0], r_lo[31]};
        w_take = (w_t >= {1'b0, r_den});
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // quotient and remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {1'b0, i_num[63:32]};
            r_lo  <= i_num[31:0];
            r_den <= i_den;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= w_take ? (w_t - {1'b0, r_den}) : w_t;
            r_lo  <= {r_lo[30:0], 1'b0};
            r_quo <= {r_quo[30:0], w_take};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

[sv/mau_dpath.sv]
// ----------------------------------------------------------------------------
// mau_dpath
// Datapath: filter state, configuration registers, one shared 34x34
// multiplier with a registered product, square root and divide units,
// and the output register.
// ----------------------------------------------------------------------------
module mau_dpath
    import mau_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    input  t_in         i_in_data,
    input  logic        i_cfg_valid,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out        o_out_data
);

    localparam logic signed [49:0] MAX32  = 50'sd2147483647;
    localparam logic signed [49:0] MIN32  = -50'sd2147483648;
    localparam logic signed [49:0] MINSYM = -50'sd2147483647;

    function automatic logic signed [31:0] sat32(input logic signed [49:0] x);
        if (x > MAX32) return MAX32[31:0];
        if (x < MIN32) return MIN32[31:0];
        return x[31:0];
    endfunction

    function automatic logic signed [31:0] satsym(input logic signed [49:0] x);
        if (x > MAX32)  return MAX32[31:0];
        if (x < MINSYM) return MINSYM[31:0];
        return x[31:0];
    endfunction

    // state and configuration
    logic signed [31:0] r_q [4];
    logic signed [31:0] r_i [3];
    logic [31:0]        r_kp, r_ki, r_dt;

    // working registers
    logic signed [31:0] r_g  [3];
    logic signed [31:0] r_a  [3];
    logic signed [33:0] r_v  [3];
    logic signed [31:0] r_e  [3];
    logic signed [47:0] r_s  [4];
    logic signed [31:0] r_nq [4];
    logic signed [35:0] r_t;
    logic [31:0]        r_sc;
    logic [63:0]        r_acc;
    logic [31:0]        r_root;
    logic signed [67:0] r_prod;
    t_out               r_out;
    logic               r_ovalid;

    // operand selection
    logic signed [33:0] w_ma, w_mb;
    logic signed [33:0] w_dt;
    logic [1:0]         w_k;
    logic [1:0]         w_si;
    logic [1:0]         w_sec;
    logic               w_neg;
    logic               w_first;

    // derived values
    logic signed [33:0] w_m30;
    logic signed [35:0] w_m30w;
    logic signed [47:0] w_m16;
    logic signed [47:0] w_term;
    logic signed [57:0] w_sum;
    logic signed [57:0] w_val;

    // iterative units
    logic        w_sq_start, w_sq_done;
    logic [63:0] w_sq_val;
    logic [31:0] w_sq_root;
    logic        w_dv_start, w_dv_done;
    logic [63:0] w_dv_num;
    logic [31:0] w_dv_quo;
    logic        w_dv_neg;
    logic signed [31:0] w_dv_res;
    logic [31:0] w_amag;
    logic [31:0] w_qmag;
    logic        w_out_free;

    assign w_k  = i_cmd.idx[1:0];
    assign w_si = i_cmd.idx[2:1];
    assign w_dt = $signed({2'b00, r_dt});

    // step sum fed by each group of three products
    always_comb begin
        case (i_cmd.idx) inside
            [4'd0:4'd2]: w_sec = 2'd0;
            [4'd3:4'd5]: w_sec = 2'd1;
            [4'd6:4'd8]: w_sec = 2'd2;
            default:     w_sec = 2'd3;
        endcase
    end

    // multiplier operands per operation and index
    always_comb begin
        w_ma    = '0;
        w_mb    = '0;
        w_neg   = 1'b0;
        w_first = 1'b0;
        case (i_cmd.op)
            OP_SQA: begin
                w_ma = 34'(r_a[w_k]);
                w_mb = 34'(r_a[w_k]);
            end
            OP_GRAV: begin
                case (i_cmd.idx[2:0])
                    3'd0:    begin w_ma = 34'(r_q[1]); w_mb = 34'(r_q[3]); end
                    3'd1:    begin w_ma = 34'(r_q[0]); w_mb = 34'(r_q[2]); end
                    3'd2:    begin w_ma = 34'(r_q[0]); w_mb = 34'(r_q[1]); end
                    3'd3:    begin w_ma = 34'(r_q[2]); w_mb = 34'(r_q[3]); end
                    3'd4:    begin w_ma = 34'(r_q[0]); w_mb = 34'(r_q[0]); end
                    3'd5:    begin w_ma = 34'(r_q[1]); w_mb = 34'(r_q[1]); end
                    3'd6:    begin w_ma = 34'(r_q[2]); w_mb = 34'(r_q[2]); end
                    default: begin w_ma = 34'(r_q[3]); w_mb = 34'(r_q[3]); end
                endcase
            end
            OP_ERR: begin
                case (i_cmd.idx[2:0])
                    3'd0:    begin w_ma = 34'(r_a[1]); w_mb = r_v[2]; end
                    3'd1:    begin w_ma = 34'(r_a[2]); w_mb = r_v[1]; end
                    3'd2:    begin w_ma = 34'(r_a[2]); w_mb = r_v[0]; end
                    3'd3:    begin w_ma = 34'(r_a[0]); w_mb = r_v[2]; end
                    3'd4:    begin w_ma = 34'(r_a[0]); w_mb = r_v[1]; end
                    default: begin w_ma = 34'(r_a[1]); w_mb = r_v[0]; end
                endcase
            end
            OP_INTEG: begin
                w_ma = 34'(r_e[w_k]);
                w_mb = w_dt;
            end
            OP_GAIN: begin
                if (!i_cmd.idx[0]) begin
                    w_ma = $signed({2'b00, r_kp});
                    w_mb = 34'(r_e[w_si]);
                end else begin
                    w_ma = $signed({2'b00, r_ki});
                    w_mb = 34'(r_i[w_si]);
                end
            end
            OP_STEP: begin
                case (i_cmd.idx)
                    4'd0:  begin w_ma = 34'(r_q[1]); w_mb = 34'(r_g[0]);
                                 w_neg = 1'b1; w_first = 1'b1; end
                    4'd1:  begin w_ma = 34'(r_q[2]); w_mb = 34'(r_g[1]); w_neg = 1'b1; end
                    4'd2:  begin w_ma = 34'(r_q[3]); w_mb = 34'(r_g[2]); w_neg = 1'b1; end
                    4'd3:  begin w_ma = 34'(r_q[0]); w_mb = 34'(r_g[0]); w_first = 1'b1; end
                    4'd4:  begin w_ma = 34'(r_q[2]); w_mb = 34'(r_g[2]); end
                    4'd5:  begin w_ma = 34'(r_q[3]); w_mb = 34'(r_g[1]); w_neg = 1'b1; end
                    4'd6:  begin w_ma = 34'(r_q[0]); w_mb = 34'(r_g[1]); w_first = 1'b1; end
                    4'd7:  begin w_ma = 34'(r_q[1]); w_mb = 34'(r_g[2]); w_neg = 1'b1; end
                    4'd8:  begin w_ma = 34'(r_q[3]); w_mb = 34'(r_g[0]); end
                    4'd9:  begin w_ma = 34'(r_q[0]); w_mb = 34'(r_g[2]); w_first = 1'b1; end
                    4'd10: begin w_ma = 34'(r_q[1]); w_mb = 34'(r_g[1]); end
                    default: begin w_ma = 34'(r_q[2]); w_mb = 34'(r_g[0]); w_neg = 1'b1; end
                endcase
            end
            OP_SCALE: begin
                // low 24 bits of the sum first, then the signed upper part
                if (!i_cmd.idx[0]) begin
                    w_ma = $signed({10'd0, r_s[w_si][23:0]});
                end else begin
                    w_ma = 34'($signed(r_s[w_si][47:24]));
                end
                w_mb = w_dt;
            end
            OP_NSUM: begin
                w_ma = 34'(r_nq[w_k]);
                w_mb = 34'(r_nq[w_k]);
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    // product shifts and scale sum
    always_comb begin
        w_m30  = 34'(r_prod >>> 30);
        w_m30w = 36'(r_prod >>> 30);
        w_m16  = 48'(r_prod >>> 16);
        w_term = w_neg ? -w_m16 : w_m16;
        w_sum  = $signed(r_prod[57:0]) + $signed({26'd0, r_sc});
        w_val  = w_sum >>> 9;
    end

    // iterative unit inputs
    always_comb begin
        w_amag   = r_a[w_k][31] ? -r_a[w_k] : r_a[w_k];
        w_qmag   = r_nq[w_k][31] ? -r_nq[w_k] : r_nq[w_k];
        w_sq_start = !i_cmd.wb && ((i_cmd.op == OP_ASQRT) ||
                     ((i_cmd.op == OP_QSQRT) && (r_acc != '0)));
        w_sq_val   = (i_cmd.op == OP_ASQRT) ? {r_acc[31:0], 32'd0} : r_acc;
        w_dv_start = !i_cmd.wb && ((i_cmd.op == OP_ADIV) || (i_cmd.op == OP_QDIV));
        w_dv_num   = (i_cmd.op == OP_ADIV) ? {2'b00, w_amag[15:0], 46'd0}
                                           : {3'b000, w_qmag[30:0], 30'd0};
        w_dv_neg   = (i_cmd.op == OP_ADIV) ? r_a[w_k][31] : r_nq[w_k][31];
        w_dv_res   = w_dv_neg ? -$signed(w_dv_quo) : $signed(w_dv_quo);
        w_out_free = !r_ovalid || i_out_ready;
    end

    mau_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sq_start),
        .i_val   (w_sq_val),
        .o_done  (w_sq_done),
        .o_root  (w_sq_root)
    );

    mau_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_dv_start),
        .i_num   (w_dv_num),
        .i_den   (r_root),
        .o_done  (w_dv_done),
        .o_quo   (w_dv_quo)
    );

    // filter state, configuration and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q[0]   <= Q_ONE;
            r_q[1]   <= '0;
            r_q[2]   <= '0;
            r_q[3]   <= '0;
            r_i[0]   <= '0;
            r_i[1]   <= '0;
            r_i[2]   <= '0;
            r_kp     <= KP_RESET;
            r_ki     <= KI_RESET;
            r_dt     <= DT_RESET;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_KP:  r_kp <= i_cfg_data;
                    CFG_KI:  r_ki <= i_cfg_data;
                    CFG_DT:  r_dt <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.op == OP_INTEG && i_cmd.wb) begin
                r_i[w_k] <= sat32(50'(r_i[w_k]) + 50'(r_prod >>> 38));
            end
            if (i_cmd.op == OP_QDIV && w_dv_done) begin
                r_q[w_k] <= w_dv_res;
            end
            if (i_cmd.op == OP_OUT && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_prod <= w_ma * w_mb;
        if (w_sq_done) begin
            r_root <= w_sq_root;
        end
        if (i_cmd.op == OP_ADIV && w_dv_done) begin
            r_a[w_k] <= w_dv_res;
        end
        if (i_cmd.op == OP_OUT && w_out_free) begin
            r_out <= '{quat_w: r_q[0], quat_x: r_q[1], quat_y: r_q[2], quat_z: r_q[3]};
        end
        case (i_cmd.op)
            OP_LOAD: begin
                r_g[0] <= i_in_data.rate_x;
                r_g[1] <= i_in_data.rate_y;
                r_g[2] <= i_in_data.rate_z;
                r_a[0] <= 32'(i_in_data.accel_x);
                r_a[1] <= 32'(i_in_data.accel_y);
                r_a[2] <= 32'(i_in_data.accel_z);
            end
            OP_SQA, OP_NSUM: begin
                if (i_cmd.wb) begin
                    r_acc <= ((w_k == 2'd0) ? 64'd0 : r_acc) + r_prod[63:0];
                end
            end
            OP_GRAV: begin
                if (i_cmd.wb) begin
                    case (i_cmd.idx[2:0])
                        3'd0:    r_v[0] <= w_m30;
                        3'd1:    r_v[0] <= (r_v[0] - w_m30) <<< 1;
                        3'd2:    r_v[1] <= w_m30;
                        3'd3:    r_v[1] <= (r_v[1] + w_m30) <<< 1;
                        3'd4:    r_v[2] <= w_m30;
                        3'd5:    r_v[2] <= r_v[2] - w_m30;
                        3'd6:    r_v[2] <= r_v[2] - w_m30;
                        default: r_v[2] <= r_v[2] + w_m30;
                    endcase
                end
            end
            OP_ERR: begin
                if (i_cmd.wb) begin
                    if (!i_cmd.idx[0]) begin
                        r_t <= w_m30w;
                    end else begin
                        r_e[w_si] <= sat32(50'(r_t) - 50'(w_m30w));
                    end
                end
            end
            OP_GAIN: begin
                if (i_cmd.wb) begin
                    if (!i_cmd.idx[0]) begin
                        r_t <= w_m30w;
                    end else begin
                        r_g[w_si] <= sat32(50'(r_g[w_si]) + 50'(r_t)
                                           + 50'(r_prod >>> 24));
                    end
                end
            end
            OP_STEP: begin
                if (i_cmd.wb) begin
                    r_s[w_sec] <= w_first ? w_term : r_s[w_sec] + w_term;
                end
            end
            OP_SCALE: begin
                if (i_cmd.wb) begin
                    if (!i_cmd.idx[0]) begin
                        r_sc <= r_prod[55:24];
                    end else begin
                        r_nq[w_si] <= satsym(50'(r_q[w_si]) + 50'(w_val));
                    end
                end
            end
            default: ;
        endcase
    end

    // status to controller
    assign o_stat = '{
        a_zero:    (r_a[0] == '0) && (r_a[1] == '0) && (r_a[2] == '0),
        q_zero:    (r_acc == '0),
        unit_done: w_sq_done || w_dv_done,
        out_free:  w_out_free
    };

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

endmodule

[sv/mau_ctrl.sv]
// ----------------------------------------------------------------------------
// mau_ctrl
// Controller: sequences the phases of one update, each multiply as an operand
// phase then a write-back phase, and start then wait for the iterative units.
// ----------------------------------------------------------------------------
module mau_ctrl
    import mau_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state     r_state, n_state;
    logic [3:0] r_cnt, n_cnt;
    logic       r_ph, n_ph;

    t_state     w_nxt;
    logic [3:0] w_last;
    logic       w_mul;
    logic       w_unit;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_ph    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ph    <= n_ph;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_ph       = r_ph;
        o_in_ready = 1'b0;
        o_cmd      = '{op: OP_NONE, idx: r_cnt, wb: r_ph};
        w_nxt      = S_IDLE;
        w_last     = '0;
        w_mul      = 1'b0;
        w_unit     = 1'b0;

        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_CHK;
                    n_cnt    = '0;
                    n_ph     = 1'b0;
                end
            end
            S_CHK:   n_state = i_stat.a_zero ? S_STEP : S_SQA;
            S_SQA:   begin o_cmd.op = OP_SQA;   w_mul = 1'b1; w_last = LAST_SQA;
                           w_nxt = S_ASQRT; end
            S_ASQRT: begin o_cmd.op = OP_ASQRT; w_unit = 1'b1; w_last = '0;
                           w_nxt = S_ADIV; end
            S_ADIV:  begin o_cmd.op = OP_ADIV;  w_unit = 1'b1; w_last = LAST_ADIV;
                           w_nxt = S_GRAV; end
            S_GRAV:  begin o_cmd.op = OP_GRAV;  w_mul = 1'b1; w_last = LAST_GRAV;
                           w_nxt = S_ERR; end
            S_ERR:   begin o_cmd.op = OP_ERR;   w_mul = 1'b1; w_last = LAST_ERR;
                           w_nxt = S_INTEG; end
            S_INTEG: begin o_cmd.op = OP_INTEG; w_mul = 1'b1; w_last = LAST_INTEG;
                           w_nxt = S_GAIN; end
            S_GAIN:  begin o_cmd.op = OP_GAIN;  w_mul = 1'b1; w_last = LAST_GAIN;
                           w_nxt = S_STEP; end
            S_STEP:  begin o_cmd.op = OP_STEP;  w_mul = 1'b1; w_last = LAST_STEP;
                           w_nxt = S_SCALE; end
            S_SCALE: begin o_cmd.op = OP_SCALE; w_mul = 1'b1; w_last = LAST_SCALE;
                           w_nxt = S_NSUM; end
            S_NSUM:  begin o_cmd.op = OP_NSUM;  w_mul = 1'b1; w_last = LAST_NSUM;
                           w_nxt = S_QSQRT; end
            S_QSQRT: begin o_cmd.op = OP_QSQRT; w_unit = 1'b1; w_last = '0;
                           w_nxt = S_QDIV; end
            S_QDIV:  begin o_cmd.op = OP_QDIV;  w_unit = 1'b1; w_last = LAST_QDIV;
                           w_nxt = S_OUT; end
            S_OUT: begin
                o_cmd.op = OP_OUT;
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // multiply phases: operand cycle then write-back cycle
        if (w_mul) begin
            if (r_ph) begin
                n_ph = 1'b0;
                if (r_cnt == w_last) begin
                    n_state = w_nxt;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 4'd1;
                end
            end else begin
                n_ph = 1'b1;
            end
        end

        // unit phases: start then wait for done
        if (w_unit) begin
            if (!r_ph) begin
                n_ph = 1'b1;
                // degenerate quaternion keeps the previous attitude
                if (r_state == S_QSQRT && i_stat.q_zero) begin
                    n_ph    = 1'b0;
                    n_state = S_OUT;
                end
            end else if (i_stat.unit_done) begin
                n_ph = 1'b0;
                if (r_cnt == w_last) begin
                    n_state = w_nxt;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 4'd1;
                end
            end
        end
    end

endmodule

[sv/mahony_attitude_update.sv]
// ----------------------------------------------------------------------------
// mahony_attitude_update
// Attitude filter update from one gyro and accelerometer sample; keeps a
// unit quaternion and the error integrals, returns the new quaternion.
//
//   channel  direction  handshake                  payload
//   in       sink       i_in_valid / o_in_ready    t_in  (rates, accelerations)
//   out      source     o_out_valid / i_out_ready  t_out (quaternion)
//   cfg      sink       i_cfg_valid / o_cfg_ready  index, 32-bit data
//
// The two square roots and seven divisions dominate the time of one sample,
// which is shorter when the acceleration is all zero; the shared multiplier
// computes the products one after another.
// Reset restores the identity attitude, zero integrals and default gains.
// A new sample is taken only once the previous one is in the output register;
// a stalled output holds the controller before it writes the next result.
// ----------------------------------------------------------------------------
module mahony_attitude_update
    import mau_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in         i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out        o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    t_cmd  w_cmd;
    t_stat w_stat;

    // configuration writes are always taken
    assign o_cfg_ready = 1'b1;

    // sequencer
    mau_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // arithmetic and state
    mau_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
